// ----- hw/rtl/max_heap_priority_queue_top_defines.svh -----
// Assertion macros shared by the heap queue RTL modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Plain property checked on every edge outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication checked outside reset.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mhpq_pkg.sv -----
// Shared types and constants for the max-heap priority queue.
// No dependencies; imported by the controller, datapath and top level.
package mhpq_pkg;

  localparam int unsigned HEAP_DEPTH = 128;
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned OCC_W      = 8;
  localparam int unsigned STS_W      = 2;
  localparam int unsigned OUT_USED_W = 2 * DATA_W + STS_W + OCC_W + DATA_W + 1 - DATA_W;
  localparam int unsigned OUT_W      = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned PAD_W      = OUT_W - OUT_USED_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_CHK,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic up_check;
    logic up_step;
    logic dn_load;
    logic dn_check;
    logic dn_right;
    logic dn_step;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic req_err;
    logic req_pop;
    logic pop_last;
    logic at_root;
    logic up_move;
    logic dn_leaf;
    logic dn_move;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- hw/rtl/mhpq_ctrl.sv -----
// Sequencer for the heap queue: accepts a request and steps the sift loops.
// Depends on mhpq_pkg and the assertion macros header.
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  mhpq_pkg::dp_sts_t sts_i,
  output mhpq_pkg::dp_cmd_t cmd_o
);
  import mhpq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = s_tvalid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.req_err) begin
            state_d = ST_DONE;
          end else if (!sts_i.req_pop) begin
            state_d = ST_UP_CHK;
          end else if (sts_i.pop_last) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DN_LOAD;
          end
        end
      end
      ST_UP_CHK:  state_d = sts_i.at_root ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:  state_d = sts_i.up_move ? ST_UP_CHK : ST_DONE;
      ST_DN_LOAD: state_d = ST_DN_CHK;
      ST_DN_CHK:  state_d = sts_i.dn_leaf ? ST_DONE : ST_DN_RDR;
      ST_DN_RDR:  state_d = ST_DN_CMP;
      ST_DN_CMP:  state_d = sts_i.dn_move ? ST_DN_CHK : ST_DONE;
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = accept;
      end
      ST_UP_CHK:  cmd_o.up_check = 1'b1;
      ST_UP_CMP:  cmd_o.up_step  = 1'b1;
      ST_DN_LOAD: cmd_o.dn_load  = 1'b1;
      ST_DN_CHK:  cmd_o.dn_check = 1'b1;
      ST_DN_RDR:  cmd_o.dn_right = 1'b1;
      ST_DN_CMP:  cmd_o.dn_step  = 1'b1;
      ST_DONE:    cmd_o.out_load = !sts_i.out_busy;
      default:    cmd_o = '0;
    endcase
  end

  `MHPQ_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "accept did not start work")
  `MHPQ_ASSERT_NEXT(a_done_releases, (state_q == ST_DONE) && !sts_i.out_busy, state_q == ST_IDLE, "result stuck in done")
  `MHPQ_ASSERT(a_cmp_after_chk, (state_q != ST_UP_CMP) || ($past(state_q) == ST_UP_CHK), "compare without a parent read")

endmodule

// ----- hw/rtl/mhpq_dp.sv -----
// Datapath for the heap queue: heap RAM, count, moving entry and result beat.
// Depends on mhpq_pkg and the assertion macros header.
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tuser_i,
  input  logic [mhpq_pkg::DATA_W-1:0] s_tdata_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [mhpq_pkg::OUT_W-1:0]  m_tdata_o,
  input  mhpq_pkg::dp_cmd_t          cmd_i,
  output mhpq_pkg::dp_sts_t          sts_o
);
  import mhpq_pkg::*;

  logic signed [DATA_W-1:0] mem [HEAP_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] mv_q;
  logic signed [DATA_W-1:0] left_q;
  logic signed [DATA_W-1:0] root_q;
  logic signed [DATA_W-1:0] popped_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         pos_q;
  status_e                  status_q;
  logic                     m_valid_q;
  logic [OUT_W-1:0]         m_data_q;

  logic [CNT_W:0]           two_pos;
  logic [CNT_W:0]           right_pos;
  logic [CNT_W-1:0]         parent;
  logic                     has_right;
  logic                     right_win;
  logic signed [DATA_W-1:0] child_val;
  logic [CNT_W:0]           child_pos;
  logic [ADDR_W-1:0]        pos_addr;
  logic                     req_err;
  logic                     req_ok;
  logic                     rd_en;
  logic [ADDR_W-1:0]        raddr;
  logic                     we;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] top_val;
  logic                     empty;

  assign two_pos   = {pos_q, 1'b0};
  assign right_pos = two_pos + (CNT_W+1)'(1);
  assign parent    = pos_q >> 1;
  assign pos_addr  = ADDR_W'(pos_q - CNT_W'(1));
  assign has_right = right_pos <= {1'b0, cnt_q};
  assign right_win = has_right && (rdata_q > left_q);
  assign child_val = right_win ? rdata_q : left_q;
  assign child_pos = right_win ? right_pos : two_pos;
  assign req_err   = (s_tuser_i == MODE_POP) ? (cnt_q == '0)
                                             : ({1'b0, cnt_q} >= (CNT_W+1)'(HEAP_DEPTH));
  assign req_ok    = cmd_i.accept && !req_err;
  assign empty     = (cnt_q == '0);
  assign top_val   = empty ? '0 : root_q;

  always_comb begin
    sts_o          = '0;
    sts_o.req_err  = req_err;
    sts_o.req_pop  = (s_tuser_i == MODE_POP);
    sts_o.pop_last = (cnt_q == CNT_W'(1));
    sts_o.at_root  = (pos_q == CNT_W'(1));
    sts_o.up_move  = rdata_q < mv_q;
    sts_o.dn_leaf  = two_pos > {1'b0, cnt_q};
    sts_o.dn_move  = child_val > mv_q;
    sts_o.out_busy = m_valid_q && !m_tready_i;
  end

  // Hole-based sifting: the moving entry stays in mv_q and is written once
  // at its final place; entries it passes are shifted by one level.
  always_comb begin
    rd_en = 1'b0;
    raddr = pos_addr;
    we    = 1'b0;
    wdata = mv_q;
    if (req_ok && (s_tuser_i == MODE_POP)) begin
      rd_en = 1'b1;
      raddr = ADDR_W'(cnt_q - CNT_W'(1));
    end
    if (cmd_i.up_check) begin
      if (sts_o.at_root) begin
        we = 1'b1;
      end else begin
        rd_en = 1'b1;
        raddr = ADDR_W'(parent - CNT_W'(1));
      end
    end
    if (cmd_i.up_step) begin
      we    = 1'b1;
      wdata = sts_o.up_move ? rdata_q : mv_q;
    end
    if (cmd_i.dn_check) begin
      if (sts_o.dn_leaf) begin
        we = 1'b1;
      end else begin
        rd_en = 1'b1;
        raddr = ADDR_W'(two_pos - (CNT_W+1)'(1));
      end
    end
    if (cmd_i.dn_right && has_right) begin
      rd_en = 1'b1;
      raddr = ADDR_W'(two_pos);
    end
    if (cmd_i.dn_step) begin
      we    = 1'b1;
      wdata = sts_o.dn_move ? child_val : mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pos_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_ok) begin
      cnt_q <= (s_tuser_i == MODE_POP) ? cnt_q - CNT_W'(1) : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      status_q <= !req_err ? STS_OK : ((s_tuser_i == MODE_POP) ? STS_EMPTY : STS_FULL);
      popped_q <= (req_ok && (s_tuser_i == MODE_POP)) ? root_q : '0;
    end
    if (req_ok) begin
      pos_q <= (s_tuser_i == MODE_POP) ? CNT_W'(1) : cnt_q + CNT_W'(1);
      mv_q  <= s_tdata_i;
    end
    if (cmd_i.dn_load) begin
      mv_q <= rdata_q;
    end
    if (cmd_i.up_step && sts_o.up_move) begin
      pos_q <= parent;
    end
    if (cmd_i.dn_right) begin
      left_q <= rdata_q;
    end
    if (cmd_i.dn_step && sts_o.dn_move) begin
      pos_q <= CNT_W'(child_pos);
    end
    if (we && (pos_q == CNT_W'(1))) begin
      root_q <= wdata;
    end
    if (cmd_i.out_load) begin
      m_data_q <= {{PAD_W{1'b0}}, empty, top_val, OCC_W'(cnt_q), status_q, popped_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  `MHPQ_ASSERT(a_cnt_range, {1'b0, cnt_q} <= (CNT_W+1)'(HEAP_DEPTH), "count beyond heap depth")
  `MHPQ_ASSERT_NEXT(a_cnt_only_on_accept, !cmd_i.accept, $stable(cnt_q), "count moved without a request")
  `MHPQ_ASSERT(a_err_no_pop, !m_valid_q || (m_data_q[DATA_W +: STS_W] == STS_OK) || (m_data_q[DATA_W-1:0] == '0), "failed request returned a value")

endmodule

// ----- hw/rtl/max_heap_priority_queue_top.sv -----
// Channel     Dir  Payload
// s_axis      in   tuser: mode; tdata: value
// m_axis      out  tdata: popped_value, status, occupancy, top_value, heap_empty
//
// One request at a time. An insert climbs from the new last slot toward the root
// and stops at the root or below it; a pop moves the last entry to the root and
// descends until it reaches a leaf or stops earlier. A refused request or a pop of
// the only entry goes straight to the done state. Each level costs one or two
// registered reads of the single RAM port plus a write. A finished beat waits in
// the output register while the next request is taken; a second finished beat
// holds the sequencer in its done state until the first has been taken.
// Reset clears the count and the control state; the RAM itself is not cleared.
// Dependencies: mhpq_pkg, mhpq_ctrl, mhpq_dp.
module max_heap_priority_queue_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [mhpq_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                        s_axis_tuser_i,  // [0] mode
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [31:0] popped_value, [33:32] status, [41:34] occupancy,
  // [73:42] top_value, [74] heap_empty, [79:75] zero
  output logic [mhpq_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import mhpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhpq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ----- verif/max_heap_priority_queue_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for max_heap_priority_queue_top: drives insert and pop requests
// and checks every result beat against a heap predictor kept in a scoreboard class.
// Depends on mhpq_pkg and the max_heap_priority_queue_top RTL.
module max_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  localparam int unsigned TARGET_ITEMS  = 850;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned HOLD_AT_BEAT  = 600;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam int unsigned IDLE_PCT      = 9;

  // Output beat as it sits on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [PAD_W-1:0]         pad;
    logic                     empty;
    logic signed [DATA_W-1:0] top;
    logic [OCC_W-1:0]         occupancy;
    status_e                  status;
    logic signed [DATA_W-1:0] popped;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [DATA_W-1:0] tree [HEAP_DEPTH+1];
    int unsigned              fill;
    heap_result_t             expected_q [$];
    int unsigned              error_count;

    function new();
      fill        = 0;
      error_count = 0;
    endfunction

    task report(string what);
      $display("%0t MISMATCH: %s", $time, what);
      error_count++;
    endtask

    function void swap_entries(int unsigned a, int unsigned b);
      logic signed [DATA_W-1:0] t;
      t       = tree[a];
      tree[a] = tree[b];
      tree[b] = t;
    endfunction

    function void note_request(logic mode, logic signed [DATA_W-1:0] value);
      heap_result_t exp;
      int unsigned  pos;
      int unsigned  child;
      bit           settled;
      exp        = '0;
      exp.status = STS_OK;
      if (mode == MODE_INSERT) begin
        if (fill >= HEAP_DEPTH) begin
          exp.status = STS_FULL;
        end else begin
          fill++;
          tree[fill] = value;
          pos = fill;
          while (pos > 1 && tree[pos / 2] < tree[pos]) begin
            swap_entries(pos / 2, pos);
            pos = pos / 2;
          end
        end
      end else if (fill == 0) begin
        exp.status = STS_EMPTY;
      end else begin
        exp.popped = tree[1];
        tree[1] = tree[fill];
        fill--;
        pos = 1;
        settled = 0;
        // The larger child moves up; on a tie the left child is taken.
        while (!settled && 2 * pos <= fill) begin
          child = 2 * pos;
          if (child + 1 <= fill && tree[child + 1] > tree[child]) child++;
          if (tree[child] <= tree[pos]) begin
            settled = 1;
          end else begin
            swap_entries(pos, child);
            pos = child;
          end
        end
      end
      exp.occupancy = OCC_W'(fill);
      exp.top       = (fill > 0) ? tree[1] : '0;
      exp.empty     = (fill == 0);
      expected_q.push_back(exp);
    endfunction

    task check_result(logic [OUT_W-1:0] beat);
      heap_result_t got;
      heap_result_t exp;
      got = heap_result_t'(beat);
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with nothing expected: %h", beat));
      end else begin
        exp = expected_q.pop_front();
        if (got.popped !== exp.popped)
          report($sformatf("popped_value %0d, expected %0d", got.popped, exp.popped));
        if (got.status !== exp.status)
          report($sformatf("status %0d, expected %0d", got.status, exp.status));
        if (got.occupancy !== exp.occupancy)
          report($sformatf("occupancy %0d, expected %0d", got.occupancy, exp.occupancy));
        if (got.top !== exp.top)
          report($sformatf("top_value %0d, expected %0d", got.top, exp.top));
        if (got.empty !== exp.empty)
          report($sformatf("heap_empty %0b, expected %0b", got.empty, exp.empty));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic               s_axis_tuser_i  = MODE_INSERT;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata_o;

  heap_scoreboard sb;
  int unsigned    sent_count  = 0;
  int unsigned    recv_count  = 0;
  int unsigned    quiet_count = 0;

  max_heap_priority_queue_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Mostly full-range values, with extremes and a narrow band that forces ties.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return DATA_W'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(logic mode, logic [DATA_W-1:0] value);
    // No idling on the input side for a stretch in the middle of the run.
    while (!(sent_count >= 300 && sent_count < 450) && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(mode, value);
    sent_count++;
  endtask

  task automatic run_phase(int unsigned beats, int unsigned insert_pct);
    repeat (beats) begin
      if ($urandom_range(0, 99) < insert_pct) send_request(MODE_INSERT, pick_value());
      else send_request(MODE_POP, $urandom());
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pops on an empty heap, extreme values, ties, then drain past empty.
    send_request(MODE_POP, 32'h0000_0000);
    send_request(MODE_POP, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 32'h8000_0000);
    send_request(MODE_INSERT, 32'h7FFF_FFFF);
    send_request(MODE_INSERT, 32'h0000_0000);
    send_request(MODE_INSERT, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 32'h0000_0001);
    send_request(MODE_INSERT, 32'h0000_0005);
    send_request(MODE_INSERT, 32'h0000_0005);
    send_request(MODE_INSERT, 32'h0000_0005);
    send_request(MODE_INSERT, 32'h8000_0000);
    repeat (10) send_request(MODE_POP, 32'hA5A5_A5A5);

    // Fill past capacity so inserts are refused, then drain past empty.
    run_phase(HEAP_DEPTH + 6, 100);
    run_phase(HEAP_DEPTH + 6, 0);

    while (sent_count < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        8: run_phase(HEAP_DEPTH + 12, 100);
        9: run_phase(HEAP_DEPTH + 12, 0);
        default: run_phase(40, $urandom_range(30, 70));
      endcase
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    bit held_off;
    held_off = 0;
    wait (rst_ni);
    forever begin
      if (!held_off && recv_count >= HOLD_AT_BEAT) begin
        // Long back-pressure so the block fills up and stops taking requests.
        held_off = 1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready_i <= (recv_count >= 300 && recv_count < 450)
                         || ($urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o);
        recv_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_count <= 0;
    end else if (rst_ni) begin
      quiet_count <= quiet_count + 1;
      if (quiet_count + 1 >= STALL_LIMIT) begin
        $display("%0t TIMEOUT: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
